>>> src/phm_pkg.sv
package phm_pkg;

  // Q1.15 full scale, 1.0
  localparam logic [15:0] FullScale = 16'd32768;

  // Register reset values
  localparam logic [19:0] HoldTimeRst     = 20'd1000;
  localparam logic        InfiniteHoldRst = 1'b0;
  localparam logic [15:0] DecayStepRst    = 16'd492;
  localparam logic [15:0] DecayFloorRst   = 16'd164;

  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_TIME     = 2'd0,
    CFG_INFINITE_HOLD = 2'd1,
    CFG_DECAY_STEP    = 2'd2,
    CFG_DECAY_FLOOR   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] hold_time;
    logic        infinite_hold;
    logic [15:0] decay_step;
    logic [15:0] decay_floor;
  } cfg_t;

  // One stored meter entry
  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] peak;
  } entry_t;

  // Outcome of one meter update
  typedef struct packed {
    logic [15:0] level;
    entry_t      entry;
  } upd_res_t;

endpackage

>>> src/phm_ram.sv
module phm_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/phm_update.sv
module phm_update (
  input  phm_pkg::cfg_t     cfg_i,
  input  logic [15:0]       level_raw_i,
  input  logic [31:0]       time_now_i,
  input  phm_pkg::entry_t   entry_i,
  output phm_pkg::upd_res_t res_o
);
  import phm_pkg::*;

  logic [15:0] level;
  logic [32:0] sum;
  logic [31:0] deadline_new;
  logic        new_peak;
  logic        decay;

  // Clamp to full scale
  assign level = (level_raw_i > FullScale) ? FullScale : level_raw_i;

  // Saturate the hold deadline
  assign sum          = {1'b0, time_now_i} + 33'(cfg_i.hold_time);
  assign deadline_new = (cfg_i.infinite_hold || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];

  assign new_peak = (level >= entry_i.peak);
  assign decay    = !cfg_i.infinite_hold && (time_now_i > entry_i.deadline) &&
                    (level <= cfg_i.decay_floor);

  // Replace, decay or keep the peak
  always_comb begin
    res_o.level = level;
    res_o.entry = entry_i;
    if (new_peak) begin
      res_o.entry.peak     = level;
      res_o.entry.deadline = deadline_new;
    end else if (decay) begin
      res_o.entry.peak = (entry_i.peak > cfg_i.decay_step) ?
                         entry_i.peak - cfg_i.decay_step : 16'd0;
    end
  end

endmodule

>>> src/peak_hold_meter_bank_top.sv
// Bank of peak-hold level meters. Each transfer either updates one meter
// (clamps the level to full scale, refreshes or decays its held peak) or
// clears every meter, and yields one result. One item is taken per clock
// while results drain; a result is presented from the output register:
// the registered read of the meter store lands together with the input
// register, and the update fills the output register once it is free.
// A stalled result holds the input register, which then stalls the input.
// Back-to-back updates of the same meter are forwarded, and a clear takes
// effect at once through per-meter valid bits, so no clearing pass is
// needed after reset.
module peak_hold_meter_bank_top #(
  parameter int unsigned NUM_METERS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [phm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [phm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [4:0]                    meter_index_i,
  input  logic [15:0]                   level_raw_i,
  input  logic                          clip_in_i,
  input  logic [31:0]                   time_now_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [4:0]                    meter_out_o,
  output logic [15:0]                   bar_level_o,
  output logic [15:0]                   held_peak_o,
  output logic                          clip_out_o
);
  import phm_pkg::*;

  localparam int unsigned AddrW = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
  localparam int unsigned EntryW = $bits(entry_t);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time     <= HoldTimeRst;
      cfg_q.infinite_hold <= InfiniteHoldRst;
      cfg_q.decay_step    <= DecayStepRst;
      cfg_q.decay_floor   <= DecayFloorRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HOLD_TIME:     cfg_q.hold_time     <= cfg_wdata_i[19:0];
        CFG_INFINITE_HOLD: cfg_q.infinite_hold <= cfg_wdata_i[0];
        CFG_DECAY_STEP:    cfg_q.decay_step    <= cfg_wdata_i[15:0];
        CFG_DECAY_FLOOR:   cfg_q.decay_floor   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Stage 1 (input register) and output register
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [4:0]  s1_idx_q;
  logic [15:0] s1_raw_q;
  logic        s1_clip_q;
  logic [31:0] s1_now_q;
  logic        fwd_valid_q;
  entry_t      fwd_entry_q;

  logic        out_valid_q;
  logic [4:0]  out_meter_q;
  logic [15:0] out_bar_q;
  logic [15:0] out_peak_q;
  logic        out_clip_q;

  logic [NUM_METERS-1:0] valid_q;

  logic             out_free;
  logic             s1_adv;
  logic             in_acc;
  logic             s1_clear;
  logic             s1_in_range;
  logic [AddrW-1:0] s1_addr;
  logic [AddrW-1:0] in_addr;
  logic             s1_we;
  logic [EntryW-1:0] rdata;
  entry_t           cur_entry;
  upd_res_t         upd;

  // Handshake: stage 1 moves on when the output register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_clear    = (s1_op_q == OP_CLEAR);
  assign s1_in_range = (9'(s1_idx_q) < 9'(NUM_METERS));
  assign s1_addr     = AddrW'(s1_idx_q);
  assign in_addr     = AddrW'(meter_index_i);
  assign s1_we       = s1_adv && !s1_clear && s1_in_range;

  // Meter store: {deadline, peak}
  phm_ram #(
    .Width (EntryW),
    .Depth (NUM_METERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_addr),
    .wdata_i (upd.entry),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Pick forwarded, cleared or stored entry
  always_comb begin
    if (fwd_valid_q) begin
      cur_entry = fwd_entry_q;
    end else if (!s1_in_range || !valid_q[s1_addr]) begin
      cur_entry = '0;
    end else begin
      cur_entry = entry_t'(rdata);
    end
  end

  phm_update u_update (
    .cfg_i       (cfg_q),
    .level_raw_i (s1_raw_q),
    .time_now_i  (s1_now_q),
    .entry_i     (cur_entry),
    .res_o       (upd)
  );

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload and forward of a same-meter write
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= opcode_i;
      s1_idx_q    <= meter_index_i;
      s1_raw_q    <= level_raw_i;
      s1_clip_q   <= clip_in_i;
      s1_now_q    <= time_now_i;
      fwd_valid_q <= s1_we && (s1_idx_q == meter_index_i);
      fwd_entry_q <= upd.entry;
    end
  end

  // Valid bits: drop all on clear, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_adv && s1_clear) begin
      valid_q <= '0;
    end else if (s1_we) begin
      valid_q[s1_addr] <= 1'b1;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_clear) begin
        out_meter_q <= '0;
        out_bar_q   <= '0;
        out_peak_q  <= '0;
        out_clip_q  <= 1'b0;
      end else begin
        out_meter_q <= s1_idx_q;
        out_bar_q   <= upd.level;
        out_peak_q  <= s1_in_range ? upd.entry.peak : 16'd0;
        out_clip_q  <= s1_clip_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign meter_out_o = out_meter_q;
  assign bar_level_o = out_bar_q;
  assign held_peak_o = out_peak_q;
  assign clip_out_o  = out_clip_q;

endmodule

>>> dv/meter_bank_checker.sv
module meter_bank_checker #(
  parameter int unsigned NUM_METERS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [phm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [phm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          opcode_i,
  input  logic [4:0]                    meter_index_i,
  input  logic [15:0]                   level_raw_i,
  input  logic                          clip_in_i,
  input  logic [31:0]                   time_now_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [4:0]                    meter_out_i,
  input  logic [15:0]                   bar_level_i,
  input  logic [15:0]                   held_peak_i,
  input  logic                          clip_out_i,
  output int unsigned                   n_errors_o,
  output int unsigned                   n_pending_o
);
  import phm_pkg::*;

  typedef struct packed {
    logic [4:0]  meter;
    logic [15:0] bar;
    logic [15:0] peak;
    logic        clip;
  } reading_t;

  reading_t    expected_readings[$];
  logic [15:0] peak_mem[NUM_METERS];
  logic [31:0] deadline_mem[NUM_METERS];
  cfg_t        regs;
  int unsigned err_count;

  // Advance the shadow meter bank by one transfer and return the reading it yields
  function automatic reading_t predict_reading(opcode_e op, logic [4:0] meter,
                                               logic [15:0] raw, logic clip,
                                               logic [31:0] now);
    reading_t    r;
    logic [15:0] level;
    logic [15:0] peak;
    logic [32:0] sum;
    level = (raw > FullScale) ? FullScale : raw;
    r     = '0;
    if (op == OP_CLEAR) begin
      for (int k = 0; k < NUM_METERS; k++) begin
        peak_mem[k]     = '0;
        deadline_mem[k] = '0;
      end
      return r;
    end
    peak = '0;
    if (meter < NUM_METERS) begin
      peak = peak_mem[meter];
      if (level >= peak) begin
        // new peak: restart the hold, saturate the deadline
        sum  = {1'b0, now} + {13'd0, regs.hold_time};
        peak = level;
        deadline_mem[meter] = (regs.infinite_hold || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
      end else if (!regs.infinite_hold && now > deadline_mem[meter] &&
                   level <= regs.decay_floor) begin
        peak = (peak > regs.decay_step) ? peak - regs.decay_step : 16'd0;
      end
      peak_mem[meter] = peak;
    end
    r.meter = meter;
    r.bar   = level;
    r.peak  = peak;
    r.clip  = clip;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    reading_t next_reading;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_METERS; k++) begin
        peak_mem[k]     = '0;
        deadline_mem[k] = '0;
      end
      regs.hold_time     = HoldTimeRst;
      regs.infinite_hold = InfiniteHoldRst;
      regs.decay_step    = DecayStepRst;
      regs.decay_floor   = DecayFloorRst;
      expected_readings.delete();
      err_count = 0;
    end else begin
      // Compare each result transfer against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        got = '{meter: meter_out_i, bar: bar_level_i, peak: held_peak_i, clip: clip_out_i};
        if (expected_readings.size() == 0) begin
          $error("unexpected result: meter_out %0d held_peak %0d", meter_out_i, held_peak_i);
          err_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.meter !== want.meter) begin
            $error("meter_out mismatch: expected %0d, actual %0d", want.meter, got.meter);
            err_count++;
          end
          if (got.bar !== want.bar) begin
            $error("bar_level mismatch: expected %0d, actual %0d", want.bar, got.bar);
            err_count++;
          end
          if (got.peak !== want.peak) begin
            $error("held_peak mismatch: expected %0d, actual %0d", want.peak, got.peak);
            err_count++;
          end
          if (got.clip !== want.clip) begin
            $error("clip_out mismatch: expected %0d, actual %0d", want.clip, got.clip);
            err_count++;
          end
        end
      end
      // Predict each accepted input transfer
      if (in_valid_i && !in_stall_i) begin
        next_reading = predict_reading(opcode_e'(opcode_i), meter_index_i,
                                       level_raw_i, clip_in_i, time_now_i);
        expected_readings = {expected_readings, next_reading};
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HOLD_TIME:     regs.hold_time     = cfg_wdata_i[19:0];
          CFG_INFINITE_HOLD: regs.infinite_hold = cfg_wdata_i[0];
          CFG_DECAY_STEP:    regs.decay_step    = cfg_wdata_i[15:0];
          CFG_DECAY_FLOOR:   regs.decay_floor   = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
    n_errors_o  <= err_count;
    n_pending_o <= expected_readings.size();
  end

endmodule

>>> dv/testbench.sv
module testbench;
  import phm_pkg::*;

  localparam int unsigned Meters      = 32;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [4:0]          meter_index;
  logic [15:0]         level_raw;
  logic                clip_in;
  logic [31:0]         time_now;
  logic                out_valid;
  logic                out_stall;
  logic [4:0]          meter_out;
  logic [15:0]         bar_level;
  logic [15:0]         held_peak;
  logic                clip_out;

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned idle_cycles;
  logic        sender_gaps;
  logic        quiet_tail;
  logic [31:0] clock_ms;
  logic [19:0] hold_ms;

  always #1 clk = ~clk;

  peak_hold_meter_bank_top #(.NUM_METERS(Meters)) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .meter_index_i(meter_index),
    .level_raw_i  (level_raw),
    .clip_in_i    (clip_in),
    .time_now_i   (time_now),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .meter_out_o  (meter_out),
    .bar_level_o  (bar_level),
    .held_peak_o  (held_peak),
    .clip_out_o   (clip_out)
  );

  meter_bank_checker #(.NUM_METERS(Meters)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .meter_index_i(meter_index),
    .level_raw_i  (level_raw),
    .clip_in_i    (clip_in),
    .time_now_i   (time_now),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .meter_out_i  (meter_out),
    .bar_level_i  (bar_level),
    .held_peak_i  (held_peak),
    .clip_out_i   (clip_out),
    .n_errors_o   (n_errors),
    .n_pending_o  (n_pending)
  );

  // Drop the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stall the result channel in random bursts; hold it open in the tail
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet_tail || $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Present one update or clear and hold it until the transfer happens
  task automatic send_reading(input opcode_e op, input logic [4:0] meter,
                              input logic [15:0] raw, input logic clip,
                              input logic [31:0] now);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && !quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    meter_index <= meter;
    level_raw   <= raw;
    clip_in     <= clip;
    time_now    <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every result is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic program_meters(input logic [19:0] hold, input logic inf,
                                input logic [15:0] step, input logic [15:0] floor_lvl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= CFG_INFINITE_HOLD;
    cfg_wdata <= {19'd0, inf};
    @(posedge clk);
    cfg_index <= CFG_DECAY_STEP;
    cfg_wdata <= {4'd0, step};
    @(posedge clk);
    cfg_index <= CFG_DECAY_FLOOR;
    cfg_wdata <= {4'd0, floor_lvl};
    @(posedge clk);
    cfg_we  <= 1'b0;
    hold_ms  = hold;
  endtask

  // Program a setting, then run random traffic mostly on a few busy meters
  task automatic run_phase(input logic [19:0] hold, input logic inf, input logic [15:0] step,
                           input logic [15:0] floor_lvl, input int unsigned count);
    opcode_e     op;
    logic [4:0]  meter;
    logic [15:0] raw;
    settle();
    program_meters(hold, inf, step, floor_lvl);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      // pause until the bank has answered everything
      if (i % 250 == 249) settle();
      op    = ($urandom_range(0, 49) == 0) ? OP_CLEAR : OP_UPDATE;
      meter = ($urandom_range(0, 4) < 3) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0, 1, 2: raw = 16'($urandom_range(16384, 65535));
        3, 4, 5: raw = 16'($urandom_range(0, 300));
        6:       raw = 16'($urandom_range(32760, 32780));
        default: raw = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 19))
        0:       clock_ms = $urandom();
        1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        2, 3, 4: clock_ms = clock_ms + $urandom_range(0, hold_ms + 2000);
        default: clock_ms = clock_ms + $urandom_range(0, 200);
      endcase
      send_reading(op, meter, raw, 1'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  initial begin
    sender_gaps = 1'b1;
    quiet_tail  = 1'b0;
    hold_ms     = HoldTimeRst;
    clock_ms    = '0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_HOLD_TIME;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    opcode      <= OP_UPDATE;
    meter_index <= '0;
    level_raw   <= '0;
    clip_in     <= 1'b0;
    time_now    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, hold expiry boundary, floor boundary, overflow
    send_reading(OP_UPDATE, 5'd0, 16'd0, 1'b0, 32'd0);
    send_reading(OP_UPDATE, 5'd0, 16'hFFFF, 1'b1, 32'd5);
    send_reading(OP_UPDATE, 5'd0, 16'd32769, 1'b0, 32'd10);
    send_reading(OP_UPDATE, 5'd0, 16'd100, 1'b1, 32'd1010);
    send_reading(OP_UPDATE, 5'd0, 16'd100, 1'b0, 32'd1011);
    send_reading(OP_UPDATE, 5'd0, 16'd165, 1'b0, 32'd2000);
    send_reading(OP_UPDATE, 5'd0, 16'd164, 1'b0, 32'd2000);
    send_reading(OP_UPDATE, 5'd31, 16'd32767, 1'b1, 32'hFFFF_FFFF);
    send_reading(OP_UPDATE, 5'd31, 16'd0, 1'b0, 32'hFFFF_FFFF);
    send_reading(OP_CLEAR, 5'd17, 16'hFFFF, 1'b1, 32'hA5A5_5A5A);
    send_reading(OP_UPDATE, 5'd31, 16'd0, 1'b0, 32'd1);
    send_reading(OP_UPDATE, 5'd0, 16'd50, 1'b1, 32'd9000);
    send_reading(OP_CLEAR, 5'd0, 16'd0, 1'b0, 32'd0);

    // Infinite hold pins the deadline, even after it is switched off
    settle();
    program_meters(20'd0, 1'b1, 16'hFFFF, 16'hFFFF);
    send_reading(OP_UPDATE, 5'd5, 16'd20000, 1'b0, 32'd100);
    send_reading(OP_UPDATE, 5'd5, 16'd10, 1'b0, 32'd200);
    settle();
    program_meters(20'd0, 1'b0, 16'hFFFF, 16'hFFFF);
    send_reading(OP_UPDATE, 5'd5, 16'd10, 1'b0, 32'd300);
    // Zero hold, then a decay step larger than the peak
    send_reading(OP_UPDATE, 5'd6, 16'd32768, 1'b1, 32'd301);
    send_reading(OP_UPDATE, 5'd6, 16'd50, 1'b0, 32'd302);
    send_reading(OP_UPDATE, 5'd6, 16'd65535, 1'b1, 32'd303);
    send_reading(OP_UPDATE, 5'd6, 16'd40000, 1'b0, 32'd304);
    send_reading(OP_UPDATE, 5'd7, 16'd1000, 1'b0, 32'hFFFF_FFF0);

    // Random phases across register settings, extremes included
    clock_ms = $urandom_range(0, 1000000);
    run_phase(HoldTimeRst, 1'b0, DecayStepRst, DecayFloorRst, 300);
    run_phase(20'd0, 1'b0, 16'd0, 16'd0, 200);
    run_phase(20'hFFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 150);
    run_phase(20'd50, 1'b0, 16'd4000, 16'd32768, 300);
    run_phase(20'($urandom_range(0, 5000)), 1'b0, 16'($urandom_range(0, 32768)),
              16'($urandom_range(0, 32768)), 300);
    run_phase(20'hFFFFF, 1'b0, 16'h8000, 16'h7FFF, 150);
    quiet_tail = 1'b1;
    run_phase(20'd300, 1'b0, 16'd1500, 16'd2000, 250);

    settle();
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
